### hdl/fcf_pkg.sv
// Shared constants, types and state codes of the FIR convolution filter.
`default_nettype none
package fcf_pkg;

	localparam int MAX_TAPS    = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_W      = $clog2(MAX_TAPS);
	localparam int TAP_W       = ADDR_W + 1;
	localparam int FRAC_BITS   = SAMPLE_BITS - 1;
	localparam int PROD_W      = 2 * SAMPLE_BITS;
	localparam int ACC_W       = 48;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic FUNC_COEF   = 1'b0;
	localparam logic FUNC_FILTER = 1'b1;

	typedef enum logic [1:0] {
		CMD_COEF,
		CMD_FILTER,
		CMD_PASS
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                      kind;
		logic [ADDR_W-1:0]              idx;
		logic signed [SAMPLE_BITS-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic             we;
		logic [TAP_W-1:0] taps;
	} cfg_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_ISSUE,
		BK_DRAIN,
		BK_DONE
	} back_state_t;

endpackage
`default_nettype wire

### hdl/fir_convolution_filter.sv
// Top level of the direct-form FIR convolution filter with circular history.
// Order: a coefficient write is queued and lands in the RAM when the back end pops it; a
// sample's result comes from the MAC loop, a pass-through result is loaded directly.
// Samples are filtered one at a time by the single shared MAC loop.
// Reset: arst_n clears control state; the coefficient RAM is then zeroed by a
// clearing pass over every entry, during which s_tready stays low.
`default_nettype none
module fir_convolution_filter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: tap_count
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_wdata,
	// request side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [9:0] coef_index, [25:10] value, rest zero
	input  wire logic        s_tuser,   // [0] func
	// result side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] filtered_sample
	output logic             m_tuser    // [0] saturated
);
	import fcf_pkg::*;

	cfg_t       cfg;
	back_stat_t stat;
	cmd_t       push_data;
	cmd_t       head;
	logic       q_push, q_full, q_pop, q_empty;

	// Front: take requests, classify them against the current tap count.
	fcf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.stat      (stat),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (push_data),
		.cfg       (cfg)
	);

	// Queue: hold classified requests in order so each side stalls on its own.
	fcf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (head),
		.empty     (q_empty)
	);

	// Back: write coefficients, run the MAC over the history, register the result.
	fcf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.stat     (stat),
		.q_empty  (q_empty),
		.q_head   (head),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

### hdl/fcf_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module fcf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

### hdl/fcf_front.sv
// Front end: accepts requests, holds the tap count and classifies each request.
`default_nettype none
module fcf_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [fcf_pkg::TAP_W-1:0]   cfg_wdata,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [31:0]                 s_tdata,
	input  wire logic                        s_tuser,
	input  wire fcf_pkg::back_stat_t         stat,
	input  wire logic                        q_full,
	output logic                             q_push,
	output fcf_pkg::cmd_t                    q_data,
	output fcf_pkg::cfg_t                    cfg
);
	import fcf_pkg::*;

	logic [TAP_W-1:0] taps_q;
	logic [TAP_W-1:0] taps_clamped;

	// Clamp oversized tap counts to the history depth.
	assign taps_clamped = (cfg_wdata > TAP_W'(MAX_TAPS)) ? TAP_W'(MAX_TAPS) : cfg_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= '0;
		end else if (cfg_we) begin
			taps_q <= taps_clamped;
		end
	end

	assign cfg.we   = cfg_we;
	assign cfg.taps = taps_q;

	assign s_tready = !q_full && !stat.clearing;
	assign q_push   = s_tvalid && s_tready;

	always_comb begin
		q_data.idx   = s_tdata[ADDR_W-1:0];
		q_data.value = s_tdata[ADDR_W +: SAMPLE_BITS];
		if (s_tuser == FUNC_COEF) begin
			q_data.kind = CMD_COEF;
		end else if (taps_q == '0) begin
			q_data.kind = CMD_PASS;
		end else begin
			q_data.kind = CMD_FILTER;
		end
	end

endmodule
`default_nettype wire

### hdl/fcf_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none
module fcf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire fcf_pkg::cmd_t  push_data,
	output logic                full,
	input  wire logic           pop,
	output fcf_pkg::cmd_t       head,
	output logic                empty
);
	import fcf_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/fcf_back.sv
// Back end: coefficient writes, the shared multiply-accumulate loop and the result register.
`default_nettype none
module fcf_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fcf_pkg::cfg_t                 cfg,
	output fcf_pkg::back_stat_t                stat,
	input  wire logic                          q_empty,
	input  wire fcf_pkg::cmd_t                 q_head,
	output logic                               q_pop,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [fcf_pkg::SAMPLE_BITS-1:0]    m_tdata,
	output logic                               m_tuser
);
	import fcf_pkg::*;

	back_state_t state_q, state_nx;

	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] wp_q;
	logic [TAP_W-1:0]  fill_q;
	logic [ADDR_W-1:0] pos_q;
	logic [TAP_W-1:0]  k_q;
	logic              rd_v_s1, hv_s1, last_s1;
	logic              prod_v_s2, last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic              out_valid_q, out_sat_q;
	logic [SAMPLE_BITS-1:0] out_data_q;

	logic                   coef_we, hist_we;
	logic [ADDR_W-1:0]      coef_addr, hist_addr;
	logic [SAMPLE_BITS-1:0] coef_wdata, hist_wdata;
	logic [SAMPLE_BITS-1:0] coef_rdata, hist_rdata;
	logic                   start, issue, out_load, slot_free;
	logic [ADDR_W-1:0]      p0, wp_nx;
	logic [TAP_W-1:0]       fill_nx;
	logic                   hv, last_issue, pos_wrap;
	logic [TAP_W:0]         reach;
	logic                   sat;
	logic [SAMPLE_BITS-1:0] y;
	logic [SAMPLE_BITS-1:0] res_data;
	logic                   res_sat;

	fcf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.addr  (coef_addr),
		.wdata (coef_wdata),
		.rdata (coef_rdata)
	);

	fcf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.addr  (hist_addr),
		.wdata (hist_wdata),
		.rdata (hist_rdata)
	);

	assign stat.clearing = (state_q == BK_CLEAR);
	assign slot_free     = !out_valid_q || m_tready;

	// Write position, wrapped into the active window, and its successor.
	assign p0      = ({1'b0, wp_q} >= cfg.taps) ? '0 : wp_q;
	assign wp_nx   = (p0 == '0) ? ADDR_W'(cfg.taps - 1'b1) : p0 - 1'b1;
	assign fill_nx = (fill_q == cfg.taps) ? fill_q : fill_q + 1'b1;

	// History entry is live only if a sample landed there since the last clear.
	assign reach      = {2'b00, pos_q} + {1'b0, fill_q};
	assign hv         = (fill_q != '0) && ((pos_q == '0) || (reach > {1'b0, cfg.taps}));
	assign last_issue = (k_q == cfg.taps - 1'b1);
	assign pos_wrap   = ({1'b0, pos_q} + 1'b1 == cfg.taps);

	// Shift right by the fraction bits and clip to the sample range.
	assign sat = !((&acc_q[ACC_W-1:FRAC_BITS+SAMPLE_BITS-1]) ||
	               !(|acc_q[ACC_W-1:FRAC_BITS+SAMPLE_BITS-1]));
	assign y   = sat ? {acc_q[ACC_W-1], {(SAMPLE_BITS-1){~acc_q[ACC_W-1]}}}
	                 : acc_q[FRAC_BITS +: SAMPLE_BITS];

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_CLEAR: begin
				if (clr_q == {ADDR_W{1'b1}}) begin
					state_nx = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_empty && q_head.kind == CMD_FILTER) begin
					state_nx = BK_ISSUE;
				end
			end
			BK_ISSUE: begin
				if (last_issue) begin
					state_nx = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (prod_v_s2 && last_s2) begin
					state_nx = BK_DONE;
				end
			end
			BK_DONE: begin
				if (slot_free) begin
					state_nx = BK_IDLE;
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		q_pop      = 1'b0;
		start      = 1'b0;
		issue      = 1'b0;
		out_load   = 1'b0;
		coef_we    = 1'b0;
		coef_addr  = k_q[ADDR_W-1:0];
		coef_wdata = q_head.value;
		hist_we    = 1'b0;
		hist_addr  = pos_q;
		hist_wdata = q_head.value;
		res_data   = y;
		res_sat    = sat;
		case (state_q)
			BK_CLEAR: begin
				coef_we    = 1'b1;
				coef_addr  = clr_q;
				coef_wdata = '0;
			end
			BK_IDLE: begin
				res_data = q_head.value;
				res_sat  = 1'b0;
				if (!q_empty) begin
					case (q_head.kind)
						CMD_COEF: begin
							q_pop     = 1'b1;
							coef_we   = 1'b1;
							coef_addr = q_head.idx;
						end
						CMD_PASS: begin
							q_pop    = slot_free;
							out_load = slot_free;
						end
						CMD_FILTER: begin
							q_pop     = 1'b1;
							start     = 1'b1;
							hist_we   = 1'b1;
							hist_addr = p0;
						end
						default: ;
					endcase
				end
			end
			BK_ISSUE: begin
				issue = 1'b1;
			end
			BK_DONE: begin
				out_load = slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			pos_q       <= '0;
			k_q         <= '0;
			rd_v_s1     <= 1'b0;
			prod_v_s2   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg.we) begin
				wp_q   <= '0;
				fill_q <= '0;
			end else if (start) begin
				wp_q   <= wp_nx;
				fill_q <= fill_nx;
			end
			if (start) begin
				pos_q <= p0;
				k_q   <= '0;
			end else if (issue) begin
				pos_q <= pos_wrap ? '0 : pos_q + 1'b1;
				k_q   <= k_q + 1'b1;
			end
			rd_v_s1   <= issue;
			prod_v_s2 <= rd_v_s1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		hv_s1   <= hv;
		last_s1 <= last_issue;
		last_s2 <= last_s1;
		prod_s2 <= $signed(coef_rdata) * $signed(hv_s1 ? hist_rdata : '0);
		if (start) begin
			acc_q <= '0;
		end else if (prod_v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (out_load) begin
			out_data_q <= res_data;
			out_sat_q  <= res_sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_sat_q;

endmodule
`default_nettype wire

### test/fir_convolution_filter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the FIR convolution filter: scoreboard class plus stream drivers.

typedef struct {
	logic [15:0] sample;
	logic        clipped;
} fir_output_t;

// Tracks coefficients, circular history and tap count; predicts one output per sample request.
class fir_output_board;
	logic [15:0]   coef_mem [fcf_pkg::MAX_TAPS];
	logic [15:0]   hist_mem [fcf_pkg::MAX_TAPS];
	int unsigned   head;
	int unsigned   taps;
	int unsigned   errors;
	fir_output_t   awaited[$];

	function new();
		foreach (coef_mem[i]) coef_mem[i] = '0;
		clear_history();
		taps   = 0;
		errors = 0;
	endfunction

	function void clear_history();
		foreach (hist_mem[i]) hist_mem[i] = '0;
		head = 0;
	endfunction

	// A tap count write clears the history and rewinds the write position.
	function void set_taps(logic [10:0] v);
		taps = (v > fcf_pkg::MAX_TAPS) ? fcf_pkg::MAX_TAPS : v;
		clear_history();
	endfunction

	function int unsigned outstanding();
		return awaited.size();
	endfunction

	function void take_request(logic func, logic [9:0] idx, logic [15:0] val);
		fir_output_t r;
		longint      acc;
		longint      y;
		int unsigned pos;
		int unsigned k;
		if (func == fcf_pkg::FUNC_COEF) begin
			coef_mem[idx] = val;
			return;
		end
		r.clipped = 1'b0;
		if (taps == 0) begin
			r.sample = val;
			awaited.push_back(r);
			return;
		end
		if (head >= taps)
			head = 0;
		hist_mem[head] = val;
		acc = 0;
		pos = head;
		for (k = 0; k < taps; k++) begin
			acc += longint'($signed(coef_mem[k])) * longint'($signed(hist_mem[pos]));
			pos = (pos + 1 >= taps) ? 0 : pos + 1;
		end
		y = acc >>> fcf_pkg::FRAC_BITS;
		if (y > 32767) begin
			y = 32767;
			r.clipped = 1'b1;
		end else if (y < -32768) begin
			y = -32768;
			r.clipped = 1'b1;
		end
		r.sample = 16'(y);
		head = (head == 0) ? taps - 1 : head - 1;
		awaited.push_back(r);
	endfunction

	function void check_output(logic [15:0] got, logic got_sat);
		fir_output_t want;
		if (awaited.size() == 0) begin
			$display("%0t: unexpected output sample %h saturated %b", $time, got, got_sat);
			errors++;
			return;
		end
		want = awaited.pop_front();
		if (got !== want.sample) begin
			$display("%0t: filtered_sample expected %h actual %h", $time, want.sample, got);
			errors++;
		end
		if (got_sat !== want.clipped) begin
			$display("%0t: saturated expected %b actual %b", $time, want.clipped, got_sat);
			errors++;
		end
	endfunction
endclass

module fir_convolution_filter_tb;
	import fcf_pkg::*;

	localparam int STALL_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 32;
	localparam int DRAIN_CYCLES  = 64;
	localparam int ITEM_TARGET   = 550;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [10:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;

	fir_output_board board;
	int unsigned     sent;
	int unsigned     stall_cycles = 0;
	bit              sender_steady;

	fir_convolution_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [9:0] coef_index, [25:10] value, rest zero
		.s_tuser   (s_tuser),   // [0] func
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [15:0] filtered_sample
		.m_tuser   (m_tuser)    // [0] saturated
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 150);
	endfunction

	// Favor the extremes of Q1.15 when pushing for saturation.
	function automatic logic [15:0] pick_value(bit loud);
		if ($urandom_range(0, 99) < (loud ? 80 : 12)) begin
			case ($urandom_range(0, 4))
				0: return 16'h7FFF;
				1: return 16'h8000;
				2: return 16'h0000;
				3: return 16'h0001;
				default: return 16'hFFFF;
			endcase
		end
		return 16'($urandom_range(0, 65535));
	endfunction

	// Present one request and hold it until the filter takes it. Valid is left high
	// after acceptance so a back-to-back request never drops it within one step.
	task automatic send_item(logic func, logic [9:0] idx, logic [15:0] val);
		int unsigned gap;
		gap = sender_steady ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, val, idx};
		s_tuser  <= func;
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		board.take_request(func, idx, val);
		sent++;
	endtask

	task automatic stop_requests();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// Write tap_count only once the filter is idle: drain every result, then let
	// trailing coefficient writes retire before the register changes.
	task automatic write_taps(logic [10:0] v);
		stop_requests();
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		board.set_taps(v);
	endtask

	// One random phase: pick a tap count, then a mix of coefficient writes and samples.
	// Large tap counts are slow, so keep those phases short.
	task automatic run_phase();
		logic [10:0] taps_cfg;
		int unsigned live;
		int unsigned count;
		int unsigned r;
		logic [9:0]  idx;
		bit          loud;
		r = $urandom_range(0, 99);
		if (r < 10)
			taps_cfg = 11'd0;
		else if (r < 14)
			taps_cfg = 11'($urandom_range(1024, 2047));
		else if (r < 22)
			taps_cfg = 11'($urandom_range(41, 255));
		else
			taps_cfg = 11'($urandom_range(1, 40));
		write_taps(taps_cfg);
		live = (taps_cfg > MAX_TAPS) ? MAX_TAPS : taps_cfg;
		if (live >= 256)
			count = $urandom_range(4, 10);
		else if (live > 40)
			count = $urandom_range(10, 25);
		else
			count = $urandom_range(20, 60);
		loud          = ($urandom_range(0, 3) == 0);
		sender_steady = ($urandom_range(0, 4) == 0);
		repeat (count) begin
			if ($urandom_range(0, 99) < 30) begin
				// Mostly aim at taps in use; the rest lands anywhere in the store.
				if (live > 0 && $urandom_range(0, 3) != 0)
					idx = 10'($urandom_range(0, live - 1));
				else
					idx = 10'($urandom_range(0, 1023));
				send_item(FUNC_COEF, idx, pick_value(loud));
			end else begin
				send_item(FUNC_FILTER, 10'($urandom_range(0, 1023)), pick_value(loud));
			end
		end
		sender_steady = 1'b0;
	endtask

	// Result side: alternate ready runs with stalls, including long steady runs.
	initial begin : result_sink
		int unsigned hold;
		int unsigned run;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = pick_gap();
			if (hold > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 20);
			repeat (run) @(negedge clk);
		end
	end

	// Check every output the filter hands over.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_output(m_tdata, m_tuser);
	end

	// Watchdog: end the run when nothing moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("fir_convolution_filter verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : stimulus
		board         = new();
		sent          = 0;
		sender_steady = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = FUNC_COEF;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Pass-through out of reset; park a coefficient at the top index for later.
		send_item(FUNC_FILTER, 10'd0, 16'h7FFF);
		send_item(FUNC_FILTER, 10'h3FF, 16'h8000);
		send_item(FUNC_FILTER, 10'd0, 16'h0000);
		send_item(FUNC_COEF, 10'h3FF, 16'h8000);

		// Single tap: positive clip, full-scale products, and floor rounding of -1.
		write_taps(11'd1);
		send_item(FUNC_COEF, 10'd0, 16'h8000);
		send_item(FUNC_FILTER, 10'd0, 16'h8000);
		send_item(FUNC_FILTER, 10'd0, 16'h7FFF);
		send_item(FUNC_COEF, 10'd0, 16'hFFFF);
		send_item(FUNC_FILTER, 10'd0, 16'h0001);
		send_item(FUNC_COEF, 10'd0, 16'h7FFF);
		send_item(FUNC_FILTER, 10'd0, 16'h8000);

		// Two taps: drive the accumulator past both rails.
		write_taps(11'd2);
		send_item(FUNC_COEF, 10'd1, 16'h8000);
		send_item(FUNC_FILTER, 10'd0, 16'h8000);
		send_item(FUNC_FILTER, 10'd0, 16'h8000);
		send_item(FUNC_FILTER, 10'd0, 16'h7FFF);
		send_item(FUNC_FILTER, 10'd0, 16'h8000);

		// Oversized count acts as the full depth; then the full depth itself.
		write_taps(11'd2047);
		send_item(FUNC_FILTER, 10'd0, 16'h8000);
		send_item(FUNC_FILTER, 10'd0, 16'h3039);
		write_taps(11'd1024);
		send_item(FUNC_FILTER, 10'd0, 16'h8000);

		// Back to pass-through with coefficients still loaded.
		write_taps(11'd0);
		send_item(FUNC_FILTER, 10'd0, 16'h0005);

		while (sent < ITEM_TARGET)
			run_phase();

		stop_requests();
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.outstanding() == 0)
			$display("fir_convolution_filter verification clean");
		else
			$display("fir_convolution_filter verification failed");
		$finish;
	end

endmodule
